// ----- sv/keyed_fifo_queue_assert.svh -----
// ----------------------------------------------------------------------------
// keyed_fifo_queue assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_FIFO_QUEUE_ASSERT_SVH
`define KEYED_FIFO_QUEUE_ASSERT_SVH

// property holds at every edge
`define KFQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define KFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define KFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kfq_pkg.sv -----
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared constants, control word types and helpers of the keyed FIFO queue.
// ----------------------------------------------------------------------------
package kfq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam int unsigned OP_W  = 3;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  localparam int unsigned IN_PAYLOAD_W  = KEY_W + VAL_W;
  localparam int unsigned IN_TDATA_W    = ((IN_PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAYLOAD_W = KEY_W + VAL_W + 2 * CNT_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
  localparam logic [OP_W-1:0] OP_PURGE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    A_NONE,
    A_ENQ,
    A_RDHEAD,
    A_TAKE,
    A_SCINIT,
    A_SCAN,
    A_SCEND,
    A_EMIT
  } act_e;

  typedef struct packed {
    logic accept;
    act_e act;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic scan_more;
  } flags_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] occupancy;
  } result_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/kfq_useq.sv -----
// ----------------------------------------------------------------------------
// kfq_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module kfq_useq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [kfq_pkg::OP_W-1:0] opcode_i,
  input  kfq_pkg::flags_t          flags_i,
  input  logic                     out_free_i,
  output kfq_pkg::ctrl_t           ctrl_o
);

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_DISPATCH,
    J_EMPTY,
    J_LOOP,
    J_OUTFREE,
    J_ALWAYS
  } jc_e;

  typedef struct packed {
    logic          accept;
    kfq_pkg::act_e act;
    jc_e           jc;
    upc_t          target;
  } uword_t;

  localparam upc_t U_IDLE = 3'd0;
  localparam upc_t U_ENQ  = 3'd1;
  localparam upc_t U_RDH  = 3'd2;
  localparam upc_t U_TAKE = 3'd3;
  localparam upc_t U_SCI  = 3'd4;
  localparam upc_t U_SCAN = 3'd5;
  localparam upc_t U_SCE  = 3'd6;
  localparam upc_t U_FIN  = 3'd7;

  function automatic uword_t rom(input upc_t a);
    uword_t w;
    case (a)
      U_IDLE:  w = '{1'b1, kfq_pkg::A_NONE,   J_DISPATCH, U_IDLE};
      U_ENQ:   w = '{1'b0, kfq_pkg::A_ENQ,    J_ALWAYS,   U_FIN};
      U_RDH:   w = '{1'b0, kfq_pkg::A_RDHEAD, J_EMPTY,    U_FIN};
      U_TAKE:  w = '{1'b0, kfq_pkg::A_TAKE,   J_ALWAYS,   U_FIN};
      U_SCI:   w = '{1'b0, kfq_pkg::A_SCINIT, J_EMPTY,    U_FIN};
      U_SCAN:  w = '{1'b0, kfq_pkg::A_SCAN,   J_LOOP,     U_SCE};
      U_SCE:   w = '{1'b0, kfq_pkg::A_SCEND,  J_NEXT,     U_FIN};
      U_FIN:   w = '{1'b0, kfq_pkg::A_EMIT,   J_OUTFREE,  U_IDLE};
      default: w = '{1'b0, kfq_pkg::A_NONE,   J_ALWAYS,   U_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input logic [kfq_pkg::OP_W-1:0] op);
    upc_t t;
    case (op) inside
      kfq_pkg::OP_ENQ:                   t = U_ENQ;
      kfq_pkg::OP_DEQ, kfq_pkg::OP_PEEK:  t = U_RDH;
      kfq_pkg::OP_FIND, kfq_pkg::OP_PURGE: t = U_SCI;
      default:                           t = U_FIN;
    endcase
    return t;
  endfunction

  upc_t   upc_q, upc_d;
  uword_t uw;

  always_comb begin
    uw    = rom(upc_q);
    upc_d = upc_q + 1'b1;
    case (uw.jc)
      J_NEXT:     upc_d = upc_q + 1'b1;
      J_DISPATCH: upc_d = in_valid_i ? dispatch(opcode_i) : upc_q;
      J_EMPTY:    if (flags_i.empty) upc_d = uw.target;
      J_LOOP:     if (flags_i.scan_more) upc_d = upc_q;
      J_OUTFREE:  upc_d = out_free_i ? uw.target : upc_q;
      J_ALWAYS:   upc_d = uw.target;
      default:    upc_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.accept = uw.accept;
  assign ctrl_o.act    = uw.act;

endmodule

// ----- sv/kfq_dp.sv -----
// ----------------------------------------------------------------------------
// kfq_dp
// Datapath: circular entry store, head/tail pointers and scan/compact unit.
// ----------------------------------------------------------------------------
`include "keyed_fifo_queue_assert.svh"

module kfq_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kfq_pkg::ctrl_t            ctrl_i,
  input  logic                      in_valid_i,
  input  logic [kfq_pkg::OP_W-1:0]  opcode_i,
  input  logic [kfq_pkg::KEY_W-1:0] key_i,
  input  logic [kfq_pkg::VAL_W-1:0] value_i,
  output kfq_pkg::flags_t           flags_o,
  output kfq_pkg::result_t          result_o
);

  localparam int unsigned ENT_W = kfq_pkg::KEY_W + kfq_pkg::VAL_W;

  logic [ENT_W-1:0] mem_q [kfq_pkg::DEPTH];
  logic [ENT_W-1:0] rdata_q;

  logic [kfq_pkg::ADDR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [kfq_pkg::ADDR_W-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [kfq_pkg::CNT_W-1:0]  count_q, count_d, left_q, left_d, kept_q, kept_d;
  logic [kfq_pkg::CNT_W-1:0]  removed_q, removed_d;
  logic                       pend_q, pend_d;
  logic [kfq_pkg::OP_W-1:0]   op_q, op_d;
  logic [kfq_pkg::KEY_W-1:0]  key_q, key_d, okey_q, okey_d;
  logic [kfq_pkg::VAL_W-1:0]  val_q, val_d, oval_q, oval_d;
  logic [kfq_pkg::ST_W-1:0]   status_q, status_d;

  logic                       rd_en, wr_en;
  logic [kfq_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0]           wr_data;
  logic [kfq_pkg::KEY_W-1:0]  rkey;
  logic [kfq_pkg::VAL_W-1:0]  rval;
  logic                       empty, is_find, issue, match;

  assign rkey    = rdata_q[kfq_pkg::KEY_W-1:0];
  assign rval    = rdata_q[ENT_W-1:kfq_pkg::KEY_W];
  assign empty   = (count_q == '0);
  assign is_find = (op_q == kfq_pkg::OP_FIND);
  assign issue   = (left_q != '0);
  assign match   = pend_q && (rkey == key_q);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    left_d    = left_q;
    kept_d    = kept_q;
    removed_d = removed_q;
    pend_d    = pend_q;
    op_d      = op_q;
    key_d     = key_q;
    val_d     = val_q;
    okey_d    = okey_q;
    oval_d    = oval_q;
    status_d  = status_q;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    wr_en     = 1'b0;
    wr_addr   = tail_q;
    wr_data   = {val_q, key_q};

    if (ctrl_i.accept && in_valid_i) begin
      op_d      = opcode_i;
      key_d     = key_i;
      val_d     = value_i;
      status_d  = kfq_pkg::ST_OK;
      okey_d    = '0;
      oval_d    = '0;
      removed_d = '0;
    end

    case (ctrl_i.act)
      kfq_pkg::A_ENQ: begin
        if (count_q == kfq_pkg::CNT_W'(kfq_pkg::DEPTH)) begin
          status_d = kfq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          tail_d  = kfq_pkg::ptr_inc(tail_q);
          count_d = count_q + 1'b1;
        end
      end
      kfq_pkg::A_RDHEAD: begin
        if (empty) begin
          status_d = kfq_pkg::ST_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      kfq_pkg::A_TAKE: begin
        okey_d = rkey;
        oval_d = rval;
        if (op_q == kfq_pkg::OP_DEQ) begin
          head_d    = kfq_pkg::ptr_inc(head_q);
          count_d   = count_q - 1'b1;
          removed_d = kfq_pkg::CNT_W'(1);
        end
      end
      kfq_pkg::A_SCINIT: begin
        if (empty) begin
          status_d = kfq_pkg::ST_EMPTY;
        end else begin
          status_d = kfq_pkg::ST_NOTFOUND;
          rptr_d   = head_q;
          wptr_d   = head_q;
          left_d   = count_q;
          kept_d   = '0;
          pend_d   = 1'b0;
        end
      end
      kfq_pkg::A_SCAN: begin
        if (issue) begin
          rd_en   = 1'b1;
          rd_addr = rptr_q;
          rptr_d  = kfq_pkg::ptr_inc(rptr_q);
          left_d  = left_q - 1'b1;
        end
        pend_d = issue;
        if (match) begin
          status_d = kfq_pkg::ST_OK;
          if (is_find) begin
            okey_d = rkey;
            oval_d = rval;
          end else begin
            removed_d = removed_q + 1'b1;
          end
        end else if (pend_q && !is_find) begin
          wr_en   = 1'b1;
          wr_addr = wptr_q;
          wr_data = rdata_q;
          wptr_d  = kfq_pkg::ptr_inc(wptr_q);
          kept_d  = kept_q + 1'b1;
        end
      end
      kfq_pkg::A_SCEND: begin
        if (!is_find) begin
          count_d = kept_q;
          tail_d  = wptr_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
      left_q  <= '0;
      kept_q  <= '0;
      pend_q  <= 1'b0;
      op_q    <= kfq_pkg::OP_ENQ;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      left_q  <= left_d;
      kept_q  <= kept_d;
      pend_q  <= pend_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    val_q     <= val_d;
    okey_q    <= okey_d;
    oval_q    <= oval_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  assign flags_o.empty     = empty;
  assign flags_o.scan_more = issue && !(is_find && match);

  assign result_o.status    = status_q;
  assign result_o.key       = okey_q;
  assign result_o.value     = oval_q;
  assign result_o.removed   = removed_q;
  assign result_o.occupancy = count_q;

  `KFQ_ASSERT_ALWAYS(a_count_bound,
    count_q <= kfq_pkg::CNT_W'(kfq_pkg::DEPTH),
    "count above depth")
  `KFQ_ASSERT_IMP(a_write_src, wr_en,
    (ctrl_i.act == kfq_pkg::A_ENQ) || (ctrl_i.act == kfq_pkg::A_SCAN),
    "store write outside enqueue or scan")
  `KFQ_ASSERT_NEXT(a_enq_grow,
    (ctrl_i.act == kfq_pkg::A_ENQ) && (count_q != kfq_pkg::CNT_W'(kfq_pkg::DEPTH)),
    count_q == $past(count_q) + 1'b1,
    "enqueue did not grow count")

endmodule

// ----- sv/keyed_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// keyed_fifo_queue
// Bounded FIFO of key/value entries with peek, key search and key purge.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser holds the opcode
//   (enqueue, dequeue, peek, find, purge), tdata the key and value.
//   m_axis returns exactly one result per command: tuser holds the status,
//   tdata the returned key, value, removed count and occupancy.
// Steps:
//   enqueue writes the entry and goes to the result step; dequeue/peek
//   read the head entry, then take it; an unknown opcode goes straight to
//   the result step; find/purge scan the store one entry per cycle, find
//   stopping at its first hit. On an empty store dequeue, peek, find and
//   purge go straight to the result step. One command is in work at a time;
//   the next is taken once the result is in the output register.
// Reset:
//   The queue is empty after reset; no clearing pass is needed.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   next command is still accepted and runs up to its result step, where
//   it holds until the register frees.
// ----------------------------------------------------------------------------
module keyed_fifo_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] entry_key, [63:32] entry_value
  input  logic [kfq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] opcode
  input  logic [kfq_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] out_key, [63:32] out_value, [68:64] removed_count,
  // [73:69] occupancy, rest zero
  output logic [kfq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [kfq_pkg::ST_W-1:0]         m_axis_tuser
);

  kfq_pkg::ctrl_t   ctrl;
  kfq_pkg::flags_t  flags;
  kfq_pkg::result_t res;

  logic                            out_valid_q;
  logic [kfq_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [kfq_pkg::ST_W-1:0]        out_user_q;
  logic                            out_free, load;

  assign out_free = !out_valid_q || m_axis_tready;
  assign load     = (ctrl.act == kfq_pkg::A_EMIT) && out_free;

  kfq_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  kfq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .key_i      (s_axis_tdata[kfq_pkg::KEY_W-1:0]),
    .value_i    (s_axis_tdata[kfq_pkg::KEY_W+kfq_pkg::VAL_W-1:kfq_pkg::KEY_W]),
    .flags_o    (flags),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= kfq_pkg::OUT_TDATA_W'({res.occupancy, res.removed, res.value, res.key});
      out_user_q <= res.status;
    end
  end

  assign s_axis_tready = ctrl.accept;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
